>>> src/spf_pkg.sv
// Shared types and fixed widths of the sweep-and-prune pair finder.
package spf_pkg;

	localparam int SQ_W         = 51;  // alarm distance register
	localparam int ID_PORT_W    = 10;  // box id on the ports
	localparam int COORD_PORT_W = 24;  // corner coordinate on the ports
	localparam int CTX_W        = 8;   // context id

	localparam logic KIND_MIN = 1'b0;
	localparam logic KIND_MAX = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FIND,
		ST_MOVE
	} spf_state_t;

	// what the list read issued in the previous cycle was for
	typedef enum logic [1:0] {
		OP_NONE,
		OP_SCAN,
		OP_FIND,
		OP_MOVE
	} spf_rd_op_t;

	// tag carried alongside an entry through the distance pipeline
	typedef struct packed {
		logic valid;
		logic tail;
	} spf_tag_t;

endpackage

>>> src/spf_list_mem.sv
// Active list storage: one write port, one registered read port.
module spf_list_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 163
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/spf_dist_unit.sv
// Pair filter: per-axis gap, square, sum and threshold compare, one entry a cycle.
module spf_dist_unit
	import spf_pkg::*;
#(
	parameter int CB  = 24,
	parameter int IDW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spf_tag_t              in_tag,
	input  logic [IDW-1:0]        in_id,
	input  logic                  oth_sim,
	input  logic [CTX_W-1:0]      oth_ctx,
	input  logic [2:0][CB-1:0]    oth_lo,
	input  logic [2:0][CB-1:0]    oth_hi,
	input  logic                  new_sim,
	input  logic                  new_self,
	input  logic [CTX_W-1:0]      new_ctx,
	input  logic [2:0][CB-1:0]    new_lo,
	input  logic [2:0][CB-1:0]    new_hi,
	input  logic [SQ_W-1:0]       thr,
	output spf_tag_t              out_tag,
	output logic                  out_pass,
	output logic [IDW-1:0]        out_id
);

	localparam int SUM_W = 2 * CB + 2;

	// stage 2: gaps and flag filter
	spf_tag_t              tag_s2;
	logic [IDW-1:0]        id_s2;
	logic                  ok_s2;
	logic [2:0][CB-1:0]    gap_s2;
	logic [2:0][CB-1:0]    gap_c;

	// stage 3: squares
	spf_tag_t              tag_s3;
	logic [IDW-1:0]        id_s3;
	logic                  ok_s3;
	logic [2:0][2*CB-1:0]  sq_s3;

	// stage 4: sum and compare
	logic [SUM_W-1:0]      sum_c;
	logic [SQ_W-1:0]       sum_ext_c;
	spf_tag_t              tag_s4;
	logic [IDW-1:0]        id_s4;
	logic                  pass_s4;

	always_comb begin
		logic signed [CB:0] d1;
		logic signed [CB:0] d2;
		logic signed [CB:0] g;
		for (int a = 0; a < 3; a++) begin
			d1 = $signed({oth_lo[a][CB-1], oth_lo[a]}) - $signed({new_hi[a][CB-1], new_hi[a]});
			d2 = $signed({new_lo[a][CB-1], new_lo[a]}) - $signed({oth_hi[a][CB-1], oth_hi[a]});
			g  = d1[CB] ? '0 : d1;
			if (d2 > g) begin
				g = d2;
			end
			gap_c[a] = g[CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= in_tag;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		id_s2  <= in_id;
		ok_s2  <= (new_sim | oth_sim) & ((new_ctx != oth_ctx) | new_self);
		gap_s2 <= gap_c;
		id_s3  <= id_s2;
		ok_s3  <= ok_s2;
		for (int a = 0; a < 3; a++) begin
			sq_s3[a] <= {{CB{1'b0}}, gap_s2[a]} * {{CB{1'b0}}, gap_s2[a]};
		end
		id_s4   <= id_s3;
		pass_s4 <= ok_s3 && (sum_ext_c <= thr);
	end

	assign sum_c = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	assign sum_ext_c = SQ_W'(sum_c);

	assign out_tag  = tag_s4;
	assign out_pass = pass_s4;
	assign out_id   = id_s4;

endmodule

>>> src/sweep_prune_pair_finder.sv
// Top level of the sweep-and-prune pair finder: list sequencer and result stage.
//
// Usage: box endpoints come in sorted along the sweep axis. An endpoint is
// transferred at a rising edge with start high and busy low. Endpoints whose
// in_broad_phase is low are dropped on the spot and never raise busy.
// A max endpoint finds the oldest active entry with its box_id and removes it,
// closing the gap by copying the younger entries down one slot a cycle.
// A min endpoint streams all n entries active before it, oldest first,
// through the pair filter (gap, square, sum, compare pipeline, one entry per
// cycle); its box is appended to the list at its transfer, but when the list
// holds MAX_ACTIVE entries the box is dropped and only its pairs come out.
// Each pair shows on new_box/other_box for one cycle with pair_strobe high;
// last marks the final pair of the endpoint. The receiver cannot stall.
// A min endpoint reads its n entries over the single list port, and each passes
// the gap, square and sum-compare filter stages; a flush state follows, and its
// final pair shows in the first cycle with busy low. A max endpoint whose box
// is missing or youngest ends with the search, else the copy follows, on
// the one list port that search and copy share.
// With an empty list both kinds finish at once. The user is to write the alarm
// distance (cfg_wr_data on cfg_wr_en) only while busy is low; the block does
// not enforce it. Reset empties the list and clears the alarm distance to zero.
module sweep_prune_pair_finder
	import spf_pkg::*;
#(
	parameter int MAX_ACTIVE = 64,
	parameter int ID_BITS    = 10,
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [SQ_W-1:0]               cfg_wr_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [ID_PORT_W-1:0]          box_id,
	input  logic                          in_broad_phase,
	input  logic                          is_simulated,
	input  logic                          self_collide,
	input  logic [CTX_W-1:0]              context_id,
	input  logic signed [COORD_PORT_W-1:0] min_x,
	input  logic signed [COORD_PORT_W-1:0] min_y,
	input  logic signed [COORD_PORT_W-1:0] min_z,
	input  logic signed [COORD_PORT_W-1:0] max_x,
	input  logic signed [COORD_PORT_W-1:0] max_y,
	input  logic signed [COORD_PORT_W-1:0] max_z,
	output logic                          pair_strobe,
	output logic [ID_PORT_W-1:0]          new_box,
	output logic [ID_PORT_W-1:0]          other_box,
	output logic                          last
);

	localparam int IDX_W = $clog2(MAX_ACTIVE);
	localparam int CNT_W = $clog2(MAX_ACTIVE + 1);
	localparam int CB    = COORD_BITS;
	// entry layout: id, simulated, context, low corner xyz, high corner xyz
	localparam int ENT_W = ID_BITS + 1 + CTX_W + 6 * CB;

	// ---------------------------------------------------------------------
	// Port-side conversions
	// ---------------------------------------------------------------------
	logic [ID_BITS+ID_PORT_W-1:0] box_id_ext;
	logic [ID_BITS-1:0]           in_id;
	logic [2:0][CB-1:0]           in_lo;
	logic [2:0][CB-1:0]           in_hi;
	logic                         accept;

	assign box_id_ext = {{ID_BITS{1'b0}}, box_id};
	assign in_id      = box_id_ext[ID_BITS-1:0];
	assign in_lo      = {min_z[CB-1:0], min_y[CB-1:0], min_x[CB-1:0]};
	assign in_hi      = {max_z[CB-1:0], max_y[CB-1:0], max_x[CB-1:0]};
	assign accept     = start && !busy;

	// ---------------------------------------------------------------------
	// State
	// ---------------------------------------------------------------------
	spf_state_t          state_q, state_d;
	logic [SQ_W-1:0]     sq_alarm_dist_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    rd_idx_q;

	// the endpoint being worked on
	logic [ID_BITS-1:0]  key_id_q;
	logic                key_sim_q;
	logic                key_self_q;
	logic [CTX_W-1:0]    key_ctx_q;
	logic [2:0][CB-1:0]  key_lo_q;
	logic [2:0][CB-1:0]  key_hi_q;

	// list read in flight
	spf_rd_op_t          rd_op_s1;
	logic                rd_tail_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [ENT_W-1:0]    rd_data;

	// result hold-back: a pair waits until we know whether it is the last
	logic                pend_vld_q;
	logic [ID_BITS-1:0]  pend_id_q;
	logic                strobe_q;
	logic [ID_BITS-1:0]  new_box_q;
	logic [ID_BITS-1:0]  other_box_q;
	logic                last_q;

	// ---------------------------------------------------------------------
	// Entry fields as read
	// ---------------------------------------------------------------------
	logic [ID_BITS-1:0]  ent_id;
	logic                ent_sim;
	logic [CTX_W-1:0]    ent_ctx;
	logic [2:0][CB-1:0]  ent_lo;
	logic [2:0][CB-1:0]  ent_hi;
	logic [ENT_W-1:0]    in_entry;

	assign {ent_id, ent_sim, ent_ctx, ent_lo, ent_hi} = rd_data;
	assign in_entry = {in_id, is_simulated, context_id, in_lo, in_hi};

	// ---------------------------------------------------------------------
	// Control decode
	// ---------------------------------------------------------------------
	logic                append_en;
	logic                rd_issue;
	spf_rd_op_t          rd_op;
	logic                rd_tail;
	logic                match_s1;
	logic                find_hit;
	logic                remove_done;
	logic                move_wr;
	logic                mem_wr_en;
	logic [IDX_W-1:0]    mem_wr_addr;
	logic [ENT_W-1:0]    mem_wr_data;

	spf_tag_t            dist_tag;
	logic                dist_pass;
	logic [ID_BITS-1:0]  dist_id;
	spf_tag_t            scan_tag;

	logic                emit;
	logic [ID_BITS-1:0]  emit_id;
	logic                emit_last;

	assign append_en = accept && in_broad_phase && (kind == KIND_MIN)
	                   && (count_q < CNT_W'(MAX_ACTIVE));
	assign rd_tail   = (rd_idx_q + CNT_W'(1)) == limit_q;
	assign match_s1  = (ent_id == key_id_q);
	assign find_hit  = (state_q == ST_FIND) && (rd_op_s1 == OP_FIND) && match_s1;
	assign move_wr   = (rd_op_s1 == OP_MOVE);
	// removal ends when the hit was the youngest entry or the copy has finished
	assign remove_done = (find_hit && rd_tail_s1)
	                     || ((state_q == ST_MOVE) && move_wr && rd_tail_s1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_broad_phase && (count_q != '0)) begin
					state_d = (kind == KIND_MIN) ? ST_SCAN : ST_FIND;
				end
			end
			ST_SCAN: begin
				if (dist_tag.valid && dist_tag.tail) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (find_hit) begin
					state_d = rd_tail_s1 ? ST_IDLE : ST_MOVE;
				end else if ((rd_op_s1 == OP_FIND) && rd_tail_s1) begin
					state_d = ST_IDLE;
				end
			end
			ST_MOVE: begin
				if (move_wr && rd_tail_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_op    = OP_NONE;
		rd_issue = 1'b0;
		case (state_q)
			ST_SCAN: begin
				rd_issue = rd_idx_q < limit_q;
				rd_op    = rd_issue ? OP_SCAN : OP_NONE;
			end
			ST_FIND: begin
				rd_issue = (rd_idx_q < limit_q) && !find_hit;
				rd_op    = rd_issue ? OP_FIND : OP_NONE;
			end
			ST_MOVE: begin
				rd_issue = rd_idx_q < limit_q;
				rd_op    = rd_issue ? OP_MOVE : OP_NONE;
			end
			default: begin
				rd_op    = OP_NONE;
				rd_issue = 1'b0;
			end
		endcase
	end

	// list write: append on a min endpoint, or copy an entry one slot down
	always_comb begin
		mem_wr_en   = append_en || move_wr;
		mem_wr_addr = rd_idx_s1 - IDX_W'(1);
		mem_wr_data = rd_data;
		if (append_en) begin
			mem_wr_addr = count_q[IDX_W-1:0];
			mem_wr_data = in_entry;
		end
	end

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sq_alarm_dist_q <= '0;
			count_q         <= '0;
			limit_q         <= '0;
			rd_idx_q        <= '0;
			rd_op_s1        <= OP_NONE;
		end else begin
			state_q  <= state_d;
			rd_op_s1 <= rd_op;
			if (cfg_wr_en) begin
				sq_alarm_dist_q <= cfg_wr_data;
			end
			if (append_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (remove_done) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				limit_q  <= count_q;
				rd_idx_q <= '0;
			end else if (find_hit) begin
				rd_idx_q <= CNT_W'(rd_idx_s1) + CNT_W'(1);
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_tail_s1 <= rd_tail;
		rd_idx_s1  <= rd_idx_q[IDX_W-1:0];
		if (accept) begin
			key_id_q   <= in_id;
			key_sim_q  <= is_simulated;
			key_self_q <= self_collide;
			key_ctx_q  <= context_id;
			key_lo_q   <= in_lo;
			key_hi_q   <= in_hi;
		end
	end

	spf_list_mem #(
		.DEPTH (MAX_ACTIVE),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (rd_issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign scan_tag.valid = (rd_op_s1 == OP_SCAN);
	assign scan_tag.tail  = rd_tail_s1;

	spf_dist_unit #(
		.CB  (CB),
		.IDW (ID_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (scan_tag),
		.in_id    (ent_id),
		.oth_sim  (ent_sim),
		.oth_ctx  (ent_ctx),
		.oth_lo   (ent_lo),
		.oth_hi   (ent_hi),
		.new_sim  (key_sim_q),
		.new_self (key_self_q),
		.new_ctx  (key_ctx_q),
		.new_lo   (key_lo_q),
		.new_hi   (key_hi_q),
		.thr      (sq_alarm_dist_q),
		.out_tag  (dist_tag),
		.out_pass (dist_pass),
		.out_id   (dist_id)
	);

	// ---------------------------------------------------------------------
	// Result stage: a passing pair releases the one held before it; the
	// flush cycle releases the held pair as the last one.
	// ---------------------------------------------------------------------
	always_comb begin
		emit      = 1'b0;
		emit_id   = pend_id_q;
		emit_last = 1'b0;
		if ((state_q == ST_SCAN) && dist_tag.valid && dist_pass && pend_vld_q) begin
			emit = 1'b1;
		end else if ((state_q == ST_FLUSH) && pend_vld_q) begin
			emit      = 1'b1;
			emit_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			if ((state_q == ST_SCAN) && dist_tag.valid && dist_pass) begin
				pend_vld_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && dist_tag.valid && dist_pass) begin
			pend_id_q <= dist_id;
		end
		if (emit) begin
			new_box_q   <= key_id_q;
			other_box_q <= emit_id;
			last_q      <= emit_last;
		end
	end

	// ---------------------------------------------------------------------
	// Ports
	// ---------------------------------------------------------------------
	logic [ID_PORT_W+ID_BITS-1:0] new_box_ext;
	logic [ID_PORT_W+ID_BITS-1:0] other_box_ext;

	assign new_box_ext   = {{ID_PORT_W{1'b0}}, new_box_q};
	assign other_box_ext = {{ID_PORT_W{1'b0}}, other_box_q};

	assign busy        = (state_q != ST_IDLE);
	assign pair_strobe = strobe_q;
	assign new_box     = new_box_ext[ID_PORT_W-1:0];
	assign other_box   = other_box_ext[ID_PORT_W-1:0];
	assign last        = last_q;

endmodule

>>> src/spf_checker.sv
// Port-level checks of the pair finder, bound to the top level.
module spf_checker
	import spf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 pair_strobe,
	input logic [ID_PORT_W-1:0] new_box,
	input logic                 last
);

	// busy only rises after an endpoint transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

	// an endpoint never has a result in the cycle after its transfer
	a_no_early_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !pair_strobe)
		else $error("pair right after transfer");

	// a pair that is not the last one belongs to an endpoint still in work
	a_more_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_strobe && !last) |-> busy)
		else $error("non-final pair while idle");

	// back-to-back pairs of one endpoint carry the same new box
	a_same_new: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_strobe && $past(pair_strobe) && !$past(last)) |-> (new_box == $past(new_box)))
		else $error("new box changed within an endpoint");

endmodule

bind sweep_prune_pair_finder spf_checker u_spf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.pair_strobe (pair_strobe),
	.new_box     (new_box),
	.last        (last)
);

>>> bench/tb_top.sv
// Self-checking bench for sweep_prune_pair_finder: random endpoint sweeps against a list predictor.
`timescale 1ns / 100ps

module tb_top;
	import spf_pkg::*;

	localparam int LIST_DEPTH   = 64;         // MAX_ACTIVE of the instance
	localparam int SETTLE       = 8;          // quiet cycles before calling the block idle
	localparam int MAX_REPORTS  = 10;
	localparam int LIMIT_CYCLES = 1_000_000;

	localparam logic [SQ_W-1:0] ALARM_TOP = 51'd1 << 50;  // widest legal alarm distance

	// one box endpoint as it goes onto the ports
	typedef struct packed {
		logic                               kind;
		logic [ID_PORT_W-1:0]               id;
		logic                               bp;
		logic                               sim;
		logic                               selfc;
		logic [CTX_W-1:0]                   ctx;
		logic [2:0][COORD_PORT_W-1:0]       lo;
		logic [2:0][COORD_PORT_W-1:0]       hi;
	} endpoint_t;

	// one reported pair
	typedef struct packed {
		logic [ID_PORT_W-1:0] new_box;
		logic [ID_PORT_W-1:0] other_box;
		logic                 last;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SQ_W-1:0] cfg_wr_data = '0;
	logic start = 1'b0;
	logic busy;
	endpoint_t cur_ep = '0;
	logic pair_strobe;
	logic [ID_PORT_W-1:0] new_box;
	logic [ID_PORT_W-1:0] other_box;
	logic last;

	endpoint_t pend_q[$];          // endpoints waiting for the driver
	pair_t     pair_expect_q[$];   // pairs predicted, oldest first
	int        fails = 0;
	int        cycle_count = 0;

	// predictor copy of the active list and the alarm register
	logic [ID_PORT_W-1:0]         act_id  [LIST_DEPTH];
	logic                         act_sim [LIST_DEPTH];
	logic [CTX_W-1:0]             act_ctx [LIST_DEPTH];
	logic [2:0][COORD_PORT_W-1:0] act_lo  [LIST_DEPTH];
	logic [2:0][COORD_PORT_W-1:0] act_hi  [LIST_DEPTH];
	int                           act_n = 0;
	logic [SQ_W-1:0]              alarm_sq = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sweep_prune_pair_finder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.start          (start),
		.busy           (busy),
		.kind           (cur_ep.kind),
		.box_id         (cur_ep.id),
		.in_broad_phase (cur_ep.bp),
		.is_simulated   (cur_ep.sim),
		.self_collide   (cur_ep.selfc),
		.context_id     (cur_ep.ctx),
		.min_x          (cur_ep.lo[0]),
		.min_y          (cur_ep.lo[1]),
		.min_z          (cur_ep.lo[2]),
		.max_x          (cur_ep.hi[0]),
		.max_y          (cur_ep.hi[1]),
		.max_z          (cur_ep.hi[2]),
		.pair_strobe    (pair_strobe),
		.new_box        (new_box),
		.other_box      (other_box),
		.last           (last)
	);

	// queue tails for the driver and the checker
	task automatic add_ep(input endpoint_t e);
		pend_q.insert(pend_q.size(), e);
	endtask

	task automatic add_pair(input pair_t p);
		pair_expect_q.insert(pair_expect_q.size(), p);
	endtask

	// ------------------------------------------------------------------
	// Predictor: walks its own active list for each transferred endpoint.
	// Close: drop the oldest entry with that id, keep order of the rest.
	// Open: test every entry oldest first, queue the passing pairs, tag the
	// final one, then append the box unless the list is full.
	// ------------------------------------------------------------------
	task automatic predict_pairs(input endpoint_t e);
		longint d1, d2, g, sum;
		int i, j, a;
		pair_t held;
		logic have_held;
		if (!e.bp)
			return;
		if (e.kind == KIND_MAX) begin
			for (i = 0; i < act_n; i++)
				if (act_id[i] == e.id)
					break;
			if (i < act_n) begin
				for (j = i; j < act_n - 1; j++) begin
					act_id[j]  = act_id[j+1];
					act_sim[j] = act_sim[j+1];
					act_ctx[j] = act_ctx[j+1];
					act_lo[j]  = act_lo[j+1];
					act_hi[j]  = act_hi[j+1];
				end
				act_n--;
			end
			return;
		end
		have_held = 1'b0;
		held = '0;
		for (i = 0; i < act_n; i++) begin
			if (!(e.sim || act_sim[i]))
				continue;
			if (!(e.ctx != act_ctx[i] || e.selfc))
				continue;
			sum = 0;
			for (a = 0; a < 3; a++) begin
				// gap is zero on overlap, else the separation either way round
				d1 = longint'($signed(act_lo[i][a])) - longint'($signed(e.hi[a]));
				d2 = longint'($signed(e.lo[a])) - longint'($signed(act_hi[i][a]));
				g = 0;
				if (d1 > g) g = d1;
				if (d2 > g) g = d2;
				sum += g * g;
			end
			if (sum <= longint'(alarm_sq)) begin
				if (have_held)
					add_pair(held);
				held = '{new_box: e.id, other_box: act_id[i], last: 1'b0};
				have_held = 1'b1;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			add_pair(held);
		end
		// full list: pairs still come out, the new box is lost
		if (act_n < LIST_DEPTH) begin
			act_id[act_n]  = e.id;
			act_sim[act_n] = e.sim;
			act_ctx[act_n] = e.ctx;
			act_lo[act_n]  = e.lo;
			act_hi[act_n]  = e.hi;
			act_n++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of transfers separated by random pauses. A new item is
	// only loaded once the port is free, so start never drops between
	// back-to-back items.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : endpoint_driver
		int r;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start)
				burst_left--;
			if (burst_left <= 0 && gap_left == 0) begin
				r = $urandom_range(0, 19);
				if (r < 7)
					gap_left = 0;               // long runs with no pause at all
				else if (r < 17)
					gap_left = $urandom_range(1, 8);
				else
					gap_left = $urandom_range(10, 90); // lands anywhere in a long scan
				burst_left = $urandom_range(1, 16);
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pend_q.size() > 0) begin
				cur_ep <= pend_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks the pair shown in the cycle now ending, then feeds the
	// endpoint transferred at this edge to the predictor. One block keeps
	// the queue order fixed within the time step.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : pair_monitor
		pair_t want;
		if (arst_n) begin
			if (pair_strobe) begin
				if (pair_expect_q.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("unexpected pair new=%0d other=%0d last=%0b",
							new_box, other_box, last);
				end else begin
					want = pair_expect_q.pop_front();
					if (new_box !== want.new_box || other_box !== want.other_box ||
							last !== want.last) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("pair mismatch: exp new=%0d other=%0d last=%0b, got new=%0d other=%0d last=%0b",
								want.new_box, want.other_box, want.last,
								new_box, other_box, last);
					end
				end
			end
			if (start && !busy)
				predict_pairs(cur_ep);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic endpoint_t mk(input logic k, input int id, input logic bp,
			input logic sim, input logic selfc, input int ctx, input int lo, input int hi);
		endpoint_t e;
		int a;
		e.kind = k;
		e.id = ID_PORT_W'(id);
		e.bp = bp;
		e.sim = sim;
		e.selfc = selfc;
		e.ctx = CTX_W'(ctx);
		for (a = 0; a < 3; a++) begin
			e.lo[a] = COORD_PORT_W'(lo);
			e.hi[a] = COORD_PORT_W'(hi);
		end
		return e;
	endfunction

	// mostly boxes clustered near the origin so gaps are comparable with the
	// alarm distances; now and then raw full-range corners
	function automatic endpoint_t rand_box();
		endpoint_t e;
		int a, c, w;
		logic [COORD_PORT_W-1:0] t;
		e.kind = KIND_MIN;
		e.id = ID_PORT_W'($urandom_range(0, 1023));
		e.bp = 1'b1;
		e.sim = ($urandom_range(0, 3) != 0);
		e.selfc = ($urandom_range(0, 3) == 0);
		e.ctx = $urandom_range(0, 1) ? CTX_W'($urandom_range(0, 3)) : CTX_W'($urandom);
		for (a = 0; a < 3; a++) begin
			if ($urandom_range(0, 7) == 0) begin
				e.lo[a] = COORD_PORT_W'($urandom);
				e.hi[a] = COORD_PORT_W'($urandom);
			end else begin
				c = $urandom_range(0, 8191) - 4096;
				w = $urandom_range(0, 1500);
				e.lo[a] = COORD_PORT_W'(c);
				e.hi[a] = COORD_PORT_W'(c + w);
				if ($urandom_range(0, 19) == 0) begin
					t = e.lo[a];
					e.lo[a] = e.hi[a];
					e.hi[a] = t;
				end
			end
		end
		return e;
	endfunction

	// block idle: nothing queued or held, not busy, no pair outstanding
	task automatic drain();
		int quiet;
		quiet = 0;
		while (quiet < SETTLE) begin
			@(negedge clk);
			if (pend_q.size() == 0 && !start && !busy && pair_expect_q.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
	endtask

	task automatic write_alarm(input logic [SQ_W-1:0] v);
		drain();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		alarm_sq = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// 65 opens: the last one meets a full list, then every box is closed
	task automatic fill_list();
		endpoint_t kept[$];
		endpoint_t e;
		int k, idx;
		for (k = 0; k <= LIST_DEPTH; k++) begin
			e = rand_box();
			e.sim = 1'b1;
			add_ep(e);
			kept.insert(kept.size(), e);
		end
		while (kept.size() > 0) begin
			idx = $urandom_range(0, kept.size() - 1);
			e = kept[idx];
			kept.delete(idx);
			e.kind = KIND_MAX;
			add_ep(e);
		end
	endtask

	// well-formed open/close sweep with random content, plus some noise:
	// ignored endpoints, closes of boxes never opened, reused ids
	task automatic run_sweep(input int count, input int cap);
		endpoint_t open_q[$];
		endpoint_t e;
		int made, r, idx;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				e = rand_box();
				e.bp = 1'b0;
				e.kind = 1'($urandom_range(0, 1));
				add_ep(e);                  // ignored, not counted
			end else begin
				if (r < 13) begin
					e = rand_box();
					e.kind = KIND_MAX;
				end else if (open_q.size() > 0 && (r < 50 || open_q.size() >= cap)) begin
					idx = $urandom_range(0, open_q.size() - 1);
					e = open_q[idx];
					open_q.delete(idx);
					e.kind = KIND_MAX;
				end else begin
					e = rand_box();
					if (open_q.size() > 0 && $urandom_range(0, 9) == 0)
						e.id = open_q[$urandom_range(0, open_q.size() - 1)].id;
					open_q.insert(open_q.size(), e);
				end
				add_ep(e);
				made++;
			end
		end
		while (open_q.size() > 0) begin
			e = open_q.pop_front();
			e.kind = KIND_MAX;
			add_ep(e);
		end
	endtask

	// ------------------------------------------------------------------
	// Run: directed list cases at the reset alarm distance of zero, a full
	// list at the widest distance, then random sweeps across several
	// distances. Each phase drains before the register is rewritten.
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_ep(mk(KIND_MAX, 5, 1, 1, 0, 0, 0, 100));     // close on empty list
		add_ep(mk(KIND_MIN, 0, 1, 1, 0, 0, 0, 100));     // first box, no partner
		add_ep(mk(KIND_MIN, 1023, 1, 0, 0, 255, 50, 150)); // pairs via other's sim
		add_ep(mk(KIND_MIN, 2, 1, 0, 0, 255, 60, 160));  // skips the unsimulated one
		add_ep(mk(KIND_MIN, 3, 1, 1, 0, 255, 70, 170));  // same context, no self hits
		add_ep(mk(KIND_MIN, 4, 1, 1, 1, 255, 80, 180));  // self collide: all four
		add_ep(mk(KIND_MIN, 7, 0, 1, 1, 9, 0, 100));     // not in broad phase
		add_ep(mk(KIND_MAX, 0, 0, 1, 0, 0, 0, 100));     // ignored close
		add_ep(mk(KIND_MIN, 5, 1, 1, 0, 1, -8388608, -8388598)); // far corner, low
		add_ep(mk(KIND_MIN, 6, 1, 1, 0, 1, 8388600, 8388607));   // far corner, high
		add_ep(mk(KIND_MIN, 1023, 1, 1, 0, 9, 90, 190)); // id already active
		add_ep(mk(KIND_MAX, 1023, 1, 0, 0, 0, 0, 0));    // removes the older one
		add_ep(mk(KIND_MIN, 8, 1, 1, 0, 3, 100, 0));     // inverted corners
		add_ep(mk(KIND_MAX, 0, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 2, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 3, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 4, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 5, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 6, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 1023, 1, 0, 0, 0, 0, 0));
		add_ep(mk(KIND_MAX, 8, 1, 0, 0, 0, 0, 0));

		write_alarm(ALARM_TOP);
		fill_list();

		write_alarm('0);
		run_sweep(30, 16);

		write_alarm(SQ_W'($urandom_range(0, 1 << 26)));
		run_sweep(40, 30);

		// every bit below the top one, at random
		write_alarm({1'b0, 18'($urandom), 32'($urandom)});
		run_sweep(30, 20);

		write_alarm(SQ_W'($urandom_range(0, 1 << 22)));
		run_sweep(40, 10);

		write_alarm(ALARM_TOP);
		run_sweep(30, 24);

		drain();
		if (pair_expect_q.size() != 0) begin
			fails++;
			$display("%0d pairs never reported", pair_expect_q.size());
		end
		if (fails == 0)
			$display("PASS sweep_prune_pair_finder");
		else
			$display("FAIL sweep_prune_pair_finder");
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL sweep_prune_pair_finder");
		$finish;
	end

endmodule

>>> sim.f
src/spf_pkg.sv
src/spf_list_mem.sv
src/spf_dist_unit.sv
src/sweep_prune_pair_finder.sv
src/spf_checker.sv
bench/tb_top.sv
